### rtl/pcd_pkg.sv
package pcd_pkg;

    // trig values are q1.14, 1.0 is 16384
    localparam int TRIG_FRAC = 14;
    localparam int TRIG_ONE  = 16384;

    // angle of a quarter turn and of 1.0, both q30
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // divisors (2k)(2k+1) of the taylor series terms, k = 1 .. 10
    localparam int TAYLOR_TERMS = 10;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic
    {
        OP_COMPOSE   = 1'b0,
        OP_DECOMPOSE = 1'b1
    } op_t;

endpackage

### rtl/pcd_trig.sv
module pcd_trig
    import pcd_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int DEPTH      = 1024
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [ANGLE_BITS-1:0]         angle,
    output logic signed [TRIG_FRAC+1:0]   sin_val,
    output logic signed [TRIG_FRAC+1:0]   cos_val
);

    localparam int QB = ANGLE_BITS - 2;
    localparam int IW = $clog2(DEPTH + 1);
    localparam int MW = QB + 1 + IW;

    typedef logic [TRIG_FRAC:0] rom_t [DEPTH+1];

    // quarter-wave sine table, built at elaboration
    function automatic rom_t build_rom();
        rom_t               tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i <= DEPTH; i++)
        begin
            x    = (PI_HALF_Q30 * 64'(i) + 64'(DEPTH / 2)) / 64'(DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int k = 1; k <= TAYLOR_TERMS; k++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
                if (k % 2 == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 64'sd0;
            if (sum > $signed(ONE_Q30))
                sum = $signed(ONE_Q30);
            sum = (sum + 64'sd32768) >>> 16;
            if (sum > 64'(TRIG_ONE))
                sum = 64'(TRIG_ONE);
            tab[i] = sum[TRIG_FRAC:0];
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // fold the phase into the first quadrant and scale it to a table index
    function automatic logic [IW-1:0] rom_index(input logic [ANGLE_BITS-1:0] a);
        logic [QB:0]   p;
        logic [MW-1:0] prod;
        p = {1'b0, a[QB-1:0]};
        if (a[QB])
            p = (QB+1)'(1 << QB) - p;
        prod = MW'(p) * MW'(DEPTH) + MW'(1 << (QB - 1));
        return prod[QB +: IW];
    endfunction

    logic [ANGLE_BITS-1:0] cos_angle;
    logic [TRIG_FRAC:0]    sin_mag_reg;
    logic [TRIG_FRAC:0]    cos_mag_reg;
    logic                  sin_neg_reg;
    logic                  cos_neg_reg;

    assign cos_angle = angle + ANGLE_BITS'(1 << QB);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= SINE_ROM[rom_index(angle)];
            cos_mag_reg <= SINE_ROM[rom_index(cos_angle)];
            sin_neg_reg <= angle[ANGLE_BITS-1];
            cos_neg_reg <= cos_angle[ANGLE_BITS-1];
        end
    end

    assign sin_val = sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
    assign cos_val = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});

endmodule

### rtl/pcd_rotate.sv
module pcd_rotate
    import pcd_pkg::*;
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [POSITION_BITS:0]    ax,
    input  logic signed [POSITION_BITS:0]    ay,
    input  logic signed [TRIG_FRAC+1:0]      cos_val,
    input  logic signed [TRIG_FRAC+1:0]      sin_val,
    input  logic signed [POSITION_BITS-1:0]  add_x,
    input  logic signed [POSITION_BITS-1:0]  add_y,
    output logic signed [POSITION_BITS-1:0]  result_x,
    output logic signed [POSITION_BITS-1:0]  result_y,
    output logic                             saturated
);

    localparam int PW = POSITION_BITS + TRIG_FRAC + 3;
    localparam int SW = PW + 1;
    localparam int RW = SW - TRIG_FRAC;
    localparam int FW = RW + 1;

    logic signed [PW-1:0]            xc_reg;
    logic signed [PW-1:0]            ys_reg;
    logic signed [PW-1:0]            xs_reg;
    logic signed [PW-1:0]            yc_reg;
    logic signed [POSITION_BITS-1:0] add_x_reg;
    logic signed [POSITION_BITS-1:0] add_y_reg;

    // operands widened to the product width before the multiply
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_reg    <= PW'(ax) * PW'(cos_val);
            ys_reg    <= PW'(ay) * PW'(sin_val);
            xs_reg    <= PW'(ax) * PW'(sin_val);
            yc_reg    <= PW'(ay) * PW'(cos_val);
            add_x_reg <= add_x;
            add_y_reg <= add_y;
        end
    end

    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [FW-1:0] full_x;
    logic signed [FW-1:0] full_y;
    logic signed [FW-1:0] max_pos;
    logic signed [FW-1:0] min_pos;
    logic                 clip_x;
    logic                 clip_y;

    // round half up, then floor shift out the trig fraction
    assign sum_x = SW'(xc_reg) - SW'(ys_reg) + SW'(1 << (TRIG_FRAC - 1));
    assign sum_y = SW'(xs_reg) + SW'(yc_reg) + SW'(1 << (TRIG_FRAC - 1));

    assign full_x = FW'($signed(sum_x[SW-1:TRIG_FRAC])) + FW'(add_x_reg);
    assign full_y = FW'($signed(sum_y[SW-1:TRIG_FRAC])) + FW'(add_y_reg);

    assign max_pos = $signed({{(FW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}});
    assign min_pos = $signed({{(FW-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}});

    assign clip_x = (full_x > max_pos) || (full_x < min_pos);
    assign clip_y = (full_y > max_pos) || (full_y < min_pos);

    always_comb
    begin
        if (full_x > max_pos)
            result_x = max_pos[POSITION_BITS-1:0];
        else if (full_x < min_pos)
            result_x = min_pos[POSITION_BITS-1:0];
        else
            result_x = full_x[POSITION_BITS-1:0];

        if (full_y > max_pos)
            result_y = max_pos[POSITION_BITS-1:0];
        else if (full_y < min_pos)
            result_y = min_pos[POSITION_BITS-1:0];
        else
            result_y = full_y[POSITION_BITS-1:0];
    end

    assign saturated = clip_x || clip_y;

endmodule

### rtl/pose_compose_decompose_unit.sv
// throughput: one item per cycle, limited by nothing but the output handshake
// the two trig table reads are the only memory access, one registered read each
// stages: input register, trig table read, products, result register
// reset (rst_n low, asynchronous) clears the stage valid bits; data is not reset
module pose_compose_decompose_unit
    import pcd_pkg::*;
#(
    parameter int POSITION_BITS    = 32,
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // base_x, base_y, base_yaw, other_x, other_y, other_yaw, zero pad
    input  logic [((4*POSITION_BITS+2*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_x, result_y, result_yaw, zero pad
    output logic [((2*POSITION_BITS+ANGLE_BITS+7)/8)*8-1:0]   m_tdata,
    // saturated
    output logic                  m_tuser
);

    localparam int P      = POSITION_BITS;
    localparam int A      = ANGLE_BITS;
    localparam int OUT_W  = ((2*P + A + 7) / 8) * 8;

    // stage enables: a stage moves when it is empty or the next one moves
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_valid_reg;

    assign en4      = !out_valid_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= s_tvalid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                out_valid_reg <= v3_reg;
        end
    end

    // stage 1: input register
    op_t                   op1_reg;
    logic signed [P-1:0]   bx1_reg;
    logic signed [P-1:0]   by1_reg;
    logic [A-1:0]          byaw1_reg;
    logic signed [P-1:0]   ox1_reg;
    logic signed [P-1:0]   oy1_reg;
    logic [A-1:0]          oyaw1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg   <= op_t'(s_tuser);
            bx1_reg   <= s_tdata[P-1:0];
            by1_reg   <= s_tdata[2*P-1:P];
            byaw1_reg <= s_tdata[2*P+A-1:2*P];
            ox1_reg   <= s_tdata[3*P+A-1:2*P+A];
            oy1_reg   <= s_tdata[4*P+A-1:3*P+A];
            oyaw1_reg <= s_tdata[4*P+2*A-1:4*P+A];
        end
    end

    // compose rotates the other position; decompose rotates the full-width difference
    logic signed [P:0]   ax_next;
    logic signed [P:0]   ay_next;
    logic signed [P-1:0] add_x_next;
    logic signed [P-1:0] add_y_next;
    logic [A-1:0]        yaw_next;

    always_comb
    begin
        unique case (op1_reg)
            OP_COMPOSE:
            begin
                ax_next    = (P+1)'(ox1_reg);
                ay_next    = (P+1)'(oy1_reg);
                add_x_next = bx1_reg;
                add_y_next = by1_reg;
                yaw_next   = byaw1_reg + oyaw1_reg;
            end
            OP_DECOMPOSE:
            begin
                ax_next    = (P+1)'(ox1_reg) - (P+1)'(bx1_reg);
                ay_next    = (P+1)'(oy1_reg) - (P+1)'(by1_reg);
                add_x_next = '0;
                add_y_next = '0;
                yaw_next   = oyaw1_reg - byaw1_reg;
            end
            default:
            begin
                ax_next    = '0;
                ay_next    = '0;
                add_x_next = '0;
                add_y_next = '0;
                yaw_next   = '0;
            end
        endcase
    end

    // stage 2: trig table read alongside the prepared operands
    op_t                           op2_reg;
    logic signed [P:0]             ax2_reg;
    logic signed [P:0]             ay2_reg;
    logic signed [P-1:0]           add_x2_reg;
    logic signed [P-1:0]           add_y2_reg;
    logic [A-1:0]                  yaw2_reg;
    logic signed [TRIG_FRAC+1:0]   sin_val;
    logic signed [TRIG_FRAC+1:0]   cos_val;
    logic signed [TRIG_FRAC+1:0]   sin_eff;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            op2_reg    <= op1_reg;
            ax2_reg    <= ax_next;
            ay2_reg    <= ay_next;
            add_x2_reg <= add_x_next;
            add_y2_reg <= add_y_next;
            yaw2_reg   <= yaw_next;
        end
    end

    pcd_trig #(
        .ANGLE_BITS (A),
        .DEPTH      (SINE_TABLE_DEPTH)
    ) u_trig (
        .clk     (clk),
        .en      (en2),
        .angle   (byaw1_reg),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // decompose rotates by minus the base yaw: flip the sine
    assign sin_eff = (op2_reg == OP_DECOMPOSE) ? -sin_val : sin_val;

    // stage 3: products inside the rotator, yaw rides along
    logic [A-1:0]        yaw3_reg;
    logic signed [P-1:0] rot_x;
    logic signed [P-1:0] rot_y;
    logic                rot_sat;

    always_ff @(posedge clk)
    begin
        if (en3)
            yaw3_reg <= yaw2_reg;
    end

    pcd_rotate #(
        .POSITION_BITS (P)
    ) u_rotate (
        .clk       (clk),
        .en        (en3),
        .ax        (ax2_reg),
        .ay        (ay2_reg),
        .cos_val   (cos_val),
        .sin_val   (sin_eff),
        .add_x     (add_x2_reg),
        .add_y     (add_y2_reg),
        .result_x  (rot_x),
        .result_y  (rot_y),
        .saturated (rot_sat)
    );

    // stage 4: result register, holds while the item waits downstream
    logic [OUT_W-1:0] out_data_reg;
    logic             out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            out_data_reg <= OUT_W'({yaw3_reg, rot_y, rot_x});
            out_sat_reg  <= rot_sat;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_sat_reg;

    // an accepted item always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted item lost at input stage");

    // an item in the table stage moves on when the product stage is free
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && en3 |=> v3_reg)
        else $error("item dropped between table and product stages");

    // the saturation flag only comes with a clipped position
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (m_tdata[P-1:0] == {1'b0, {(P-1){1'b1}}}) ||
            (m_tdata[P-1:0] == {1'b1, {(P-1){1'b0}}}) ||
            (m_tdata[2*P-1:P] == {1'b0, {(P-1){1'b1}}}) ||
            (m_tdata[2*P-1:P] == {1'b1, {(P-1){1'b0}}}))
        else $error("saturated flag without a clipped position");

endmodule

### bench/tb_pose_compose_decompose_unit.sv
module tb_pose_compose_decompose_unit;
    import pcd_pkg::*;

    // block configuration as built
    localparam int POS_W      = 32;
    localparam int ANG_W      = 16;
    localparam int SINE_DEPTH = 1024;
    localparam int QUARTER    = 1 << (ANG_W - 2);
    localparam int IN_W       = ((4*POS_W+2*ANG_W+7)/8)*8;
    localparam int OUT_W      = ((2*POS_W+ANG_W+7)/8)*8;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    // one expected result
    typedef struct packed
    {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [ANG_W-1:0] yaw;
        logic                    sat;
    } pose_result_t;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // base_x, base_y, base_yaw, other_x, other_y, other_yaw
    logic [IN_W-1:0]  s_tdata  = '0;
    // operation
    logic             s_tuser  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // result_x, result_y, result_yaw
    logic [OUT_W-1:0] m_tdata;
    // saturated
    logic             m_tuser;

    // quarter-wave sine table, q1.14
    int           sine_rom [0:SINE_DEPTH];
    // poses still owed by the block, oldest first
    pose_result_t owed_poses [$];

    int error_count     = 0;
    int items_sent      = 0;
    int compose_sent    = 0;
    int results_checked = 0;
    int saturated_seen  = 0;
    int send_quiet      = 0;
    int recv_quiet      = 0;

    pose_compose_decompose_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // -------------------------------------------------------------------
    // pose arithmetic
    // -------------------------------------------------------------------

    // sin(pi/2 * idx / depth) via truncated taylor series in q30, rounded to q14
    function automatic int quarter_sine_entry(int idx);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        ang    = (PI_HALF_Q30 * 64'(idx) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int k = 1; k <= 10; k++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2*k) * (2*k+1));
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(ONE_Q30))
            acc = longint'(ONE_Q30);
        acc = (acc + 64'sd32768) >>> 16;
        if (acc > TRIG_ONE)
            acc = TRIG_ONE;
        return int'(acc);
    endfunction

    // quadrant from the top two angle bits, mirrored phase in odd quadrants
    function automatic longint angle_sine(logic [ANG_W-1:0] ang);
        int phase;
        int idx;
        phase = int'(ang[ANG_W-3:0]);
        if (ang[ANG_W-2])
            phase = QUARTER - phase;
        idx = (phase * SINE_DEPTH + QUARTER / 2) >> (ANG_W - 2);
        return ang[ANG_W-1] ? -longint'(sine_rom[idx]) : longint'(sine_rom[idx]);
    endfunction

    function automatic logic [POS_W-1:0] clip_position(longint v, inout logic flag);
        if (v > POS_MAX)
        begin
            flag = 1'b1;
            return POS_MAX[POS_W-1:0];
        end
        if (v < POS_MIN)
        begin
            flag = 1'b1;
            return POS_MIN[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

    // se(2) compose / decompose of one pose pair
    function automatic pose_result_t transform_pose
    (
        op_t                     op,
        logic signed [POS_W-1:0] bx,
        logic signed [POS_W-1:0] by,
        logic        [ANG_W-1:0] byaw,
        logic signed [POS_W-1:0] ox,
        logic signed [POS_W-1:0] oy,
        logic        [ANG_W-1:0] oyaw
    );
        logic [ANG_W-1:0] turned;
        longint           cs;
        longint           sn;
        longint           dx;
        longint           dy;
        longint           rx;
        longint           ry;
        logic             flag;
        pose_result_t     r;
        turned = byaw + QUARTER[ANG_W-1:0];
        cs     = angle_sine(turned);
        sn     = angle_sine(byaw);
        flag   = 1'b0;
        if (op == OP_COMPOSE)
        begin
            rx = ((longint'(ox) * cs - longint'(oy) * sn + 64'sd8192) >>> TRIG_FRAC)
                 + longint'(bx);
            ry = ((longint'(ox) * sn + longint'(oy) * cs + 64'sd8192) >>> TRIG_FRAC)
                 + longint'(by);
            r.yaw = byaw + oyaw;
        end
        else
        begin
            // difference kept at full width before the rotation
            dx = longint'(ox) - longint'(bx);
            dy = longint'(oy) - longint'(by);
            rx = (dx * cs + dy * sn + 64'sd8192) >>> TRIG_FRAC;
            ry = (dy * cs - dx * sn + 64'sd8192) >>> TRIG_FRAC;
            r.yaw = oyaw - byaw;
        end
        r.x   = clip_position(rx, flag);
        r.y   = clip_position(ry, flag);
        r.sat = flag;
        return r;
    endfunction

    // -------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------

    // wait length for one item, with occasional runs of back-to-back items
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            quiet_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // mix of full range, small, near the rails and tiny values
    function automatic logic [POS_W-1:0] random_position();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: return r;
            1: return {{12{r[20]}}, r[19:0]};
            2: return 32'h7FFF_FFFF - (r & 32'h0000_FFFF);
            3: return 32'h8000_0000 + (r & 32'h0000_FFFF);
            4: return {{4{r[27]}}, r[27:0]};
            default: return 32'($urandom_range(0, 2)) - 32'd1;
        endcase
    endfunction

    // full range, or at or beside a quadrant boundary
    function automatic logic [ANG_W-1:0] random_yaw();
        logic [ANG_W-1:0] q;
        if ($urandom_range(0, 3) == 0)
        begin
            q = {2'($urandom_range(0, 3)), 14'd0};
            return q + 16'($urandom_range(0, 2)) - 16'd1;
        end
        return 16'($urandom);
    endfunction

    // present one item, wait for the handshake, record what it must produce
    task automatic send_pose
    (
        input op_t              op,
        input logic [POS_W-1:0] bx,
        input logic [POS_W-1:0] by,
        input logic [ANG_W-1:0] byaw,
        input logic [POS_W-1:0] ox,
        input logic [POS_W-1:0] oy,
        input logic [ANG_W-1:0] oyaw
    );
        int           gap;
        pose_result_t want;
        gap = draw_wait(send_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {oyaw, oy, ox, byaw, by, bx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = transform_pose(op, bx, by, byaw, ox, oy, oyaw);
        owed_poses.push_back(want);
        items_sent++;
        if (op == OP_COMPOSE)
            compose_sent++;
        if (want.sat)
            saturated_seen++;
    endtask

    // -------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------

    // field extremes, both operations, quadrant angles, clipping, yaw wrap
    task automatic test_corner_poses();
        send_pose(OP_COMPOSE, 0, 0, 0, 0, 0, 0);
        send_pose(OP_COMPOSE, 0, 0, 0, 32'h0001_0000, 0, 0);
        send_pose(OP_COMPOSE, 32'h0002_0000, 0, 16'h4000, 32'h0001_0000, 32'h0003_0000, 0);
        send_pose(OP_COMPOSE, 0, 32'hFFFF_0000, 16'h8000, 32'h0001_8000, 32'h0000_4000, 16'h0100);
        send_pose(OP_COMPOSE, 32'h0000_0001, 0, 16'hC000, 32'h0005_0000, 32'hFFFB_0000, 0);
        send_pose(OP_COMPOSE, 0, 0, 16'h2000, 32'h0001_0000, 32'h0001_0000, 16'h2000);
        send_pose(OP_COMPOSE, 0, 0, 16'h7FFF, 32'h0010_0000, 32'h0020_0000, 16'h7FFF);
        // yaw wraps through pi
        send_pose(OP_COMPOSE, 0, 0, 16'h7FFF, 0, 0, 16'h0001);
        // clipping high, low and on y alone
        send_pose(OP_COMPOSE, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0);
        send_pose(OP_COMPOSE, 32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0);
        send_pose(OP_COMPOSE, 0, 32'h7FFF_FFFF, 0, 0, 32'h0000_0001, 0);
        // most negative position turned half way round
        send_pose(OP_COMPOSE, 0, 0, 16'h8000, 32'h8000_0000, 32'h8000_0000, 0);
        send_pose(OP_COMPOSE, 0, 0, 16'h2000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_pose(OP_DECOMPOSE, 0, 0, 0, 0, 0, 0);
        send_pose(OP_DECOMPOSE, 32'h1234_5678, 32'hEDCB_A988, 16'h3456,
                  32'h1234_5678, 32'hEDCB_A988, 16'h3456);
        // differences that leave the signed range
        send_pose(OP_DECOMPOSE, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
        send_pose(OP_DECOMPOSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000,
                  32'h8000_0000, 0);
        send_pose(OP_DECOMPOSE, 0, 0, 16'h0001, 0, 0, 16'h8000);
        send_pose(OP_DECOMPOSE, 32'h0001_0000, 32'h0002_0000, 16'h4000,
                  32'h0004_0000, 32'h0003_0000, 16'h4000);
        send_pose(OP_DECOMPOSE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF,
                  32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
        send_pose(OP_COMPOSE, '1, '1, '1, '1, '1, '1);
        send_pose(OP_DECOMPOSE, '1, '1, '1, '1, '1, '1);
        send_pose(OP_COMPOSE, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
    endtask

    // child poses placed in a parent frame
    task automatic test_compose_random(int count);
        repeat (count)
            send_pose(OP_COMPOSE, random_position(), random_position(), random_yaw(),
                      random_position(), random_position(), random_yaw());
    endtask

    // half the targets near the base, as relative lookups usually are
    task automatic test_decompose_random(int count);
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by;
        logic [POS_W-1:0] ox;
        logic [POS_W-1:0] oy;
        repeat (count)
        begin
            bx = random_position();
            by = random_position();
            if ($urandom_range(0, 1) == 0)
            begin
                ox = bx + {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
                oy = by + {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
            end
            else
            begin
                ox = random_position();
                oy = random_position();
            end
            send_pose(OP_DECOMPOSE, bx, by, random_yaw(), ox, oy, random_yaw());
        end
    endtask

    // both operations interleaved, raw random bits in every field for half the items
    task automatic test_mixed_operations(int count);
        op_t op;
        repeat (count)
        begin
            op = $urandom_range(0, 1) ? OP_DECOMPOSE : OP_COMPOSE;
            if ($urandom_range(0, 1) == 0)
                send_pose(op, $urandom, $urandom, 16'($urandom),
                          $urandom, $urandom, 16'($urandom));
            else
                send_pose(op, random_position(), random_position(), random_yaw(),
                          random_position(), random_position(), random_yaw());
        end
    endtask

    // -------------------------------------------------------------------
    // result side
    // -------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // receiver backpressure, one stall draw per result
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(recv_quiet);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // every accepted result against the oldest owed pose
    always @(posedge clk)
    begin
        pose_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (owed_poses.size() == 0)
                report_mismatch("result with nothing owed, x", $signed(m_tdata[31:0]), 0);
            else
            begin
                want = owed_poses.pop_front();
                results_checked++;
                if (m_tdata[31:0] !== want.x)
                    report_mismatch("result_x", $signed(m_tdata[31:0]), want.x);
                if (m_tdata[63:32] !== want.y)
                    report_mismatch("result_y", $signed(m_tdata[63:32]), want.y);
                if (m_tdata[79:64] !== want.yaw)
                    report_mismatch("result_yaw", $signed(m_tdata[79:64]), want.yaw);
                if (m_tuser !== want.sat)
                    report_mismatch("saturated", m_tuser, want.sat);
            end
        end
    end

    // -------------------------------------------------------------------
    // run
    // -------------------------------------------------------------------

    initial
    begin
        for (int i = 0; i <= SINE_DEPTH; i++)
            sine_rom[i] = quarter_sine_entry(i);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_poses();
        test_compose_random(300);
        test_decompose_random(300);
        test_mixed_operations(300);
        s_tvalid <= 1'b0;

        // drain, then wait for anything stray
        while (owed_poses.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("sent %0d pose pairs (%0d compose, %0d decompose), checked %0d results",
                 items_sent, compose_sent, items_sent - compose_sent, results_checked);
        $display("%0d results clipped, %0d mismatches", saturated_seen, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #600000;
        $display("timeout with %0d results still owed", owed_poses.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
